@@ design/bitmap_page_allocator_unit_assert.svh @@
// assertion macros used by the allocator rtl
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap page allocator: assertion failed");

// next-cycle implication, disabled while in reset
`define BPA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap page allocator: assertion failed");

`endif

@@ design/bpa_pkg.sv @@
package bpa_pkg;

	// bitmap word organisation
	localparam int WORD_W     = 64;
	localparam int WORD_BITS  = 6;
	localparam int PAGE_W     = 13;
	localparam int HINT_W     = 12;
	localparam int PAGE_SHIFT = 12;
	localparam int PTR_W      = PAGE_W - WORD_BITS;

	// command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_MARK  = 2'd2;

	typedef enum logic [1:0] {
		ST_DONE         = 2'd0,
		ST_NO_FREE      = 2'd1,
		ST_BAD_PAGE     = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] byte_addr;
	} in_item_t;

	typedef struct packed {
		logic [23:0] alloc_addr;
		status_t     status;
		logic [12:0] used_pages;
	} out_item_t;

endpackage

@@ design/bpa_ram.sv @@
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/bitmap_page_allocator_unit.sv @@
// Next-fit page frame allocator over one used bit per 4 KiB page. After reset every page is
// used, the hint is page 1 and the free count is zero; pages are handed over with mark-usable
// (cmd 2) at boot, returned with free (cmd 1, which also pulls the hint down) and taken with
// allocate (cmd 0), which searches from the hint up to the page count and then wraps from
// page 1. Each transfer in gives exactly one transfer out: the page's byte address on a
// successful allocation, a status and the number of used pages after the command. The
// bitmap sits in a single-port-read RAM of 64-bit words; each word carries a valid flag
// cleared by reset, and a word never written reads as all ones, so no clearing pass is run.
// Steps: a rejected command goes straight to the finish state; free and mark-usable read the
// word, then modify and write it back; an allocation reads one 64-page word per cycle from
// the hint up, and once more from word 0 when the search wraps, until it finds a free page.
// Only one command is in flight, so a read never meets a pending write to the same word. A
// finished result sits in the output register while the next command is taken. page_count
// may be written only while idle.
module bitmap_page_allocator_unit
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata
);

`include "bitmap_page_allocator_unit_assert.svh"

	// page_count is 13 bits, so pages beyond 8191 can never be reached
	localparam int EFF_MAX = (MAX_PAGES < 8192) ? MAX_PAGES : 8192;
	localparam int NW      = (EFF_MAX + WORD_W - 1) / WORD_W;
	localparam int AW      = (NW > 1) ? $clog2(NW) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_REL  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [PAGE_W-1:0]  page_count_q;
	logic [HINT_W-1:0]  hint_q, hint_d;
	logic [PAGE_W-1:0]  free_q, free_d;
	logic [PTR_W-1:0]   ptr_q, ptr_d;
	logic               phase_b_q, phase_b_d;
	logic [PAGE_W-1:0]  h_q, h_d;
	logic [PAGE_W-1:0]  page_q, page_d;
	logic               lower_q, lower_d;
	status_t            fin_status_q, fin_status_d;
	logic [NW-1:0]      word_vld_q;
	logic               rd_vld_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               ram_re, ram_we;
	logic [PTR_W-1:0]   ram_raddr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;

	logic [PAGE_W:0]    n_eff;
	logic [PAGE_W-1:0]  h_start;
	logic [PAGE_W-1:0]  rel_page;
	logic               rel_bad;
	logic [WORD_W-1:0]  word_eff, mask, cand;
	logic               hit;
	logic [WORD_BITS-1:0] hit_idx;
	logic [PAGE_W-1:0]  found_page;
	logic [PAGE_W:0]    last_page;
	logic [PAGE_W:0]    found_inc;
	logic [PAGE_W-1:0]  lo_bound;
	logic [PAGE_W:0]    hi_bound;
	logic               out_free;
	logic               res_load;
	logic [23:0]        res_addr;
	status_t            res_status;
	logic [PAGE_W-1:0]  res_used;

	// effective page count, capped by the bitmap size
	always_comb begin
		if ({1'b0, page_count_q} > (PAGE_W+1)'(EFF_MAX)) begin
			n_eff = (PAGE_W+1)'(EFF_MAX);
		end else begin
			n_eff = {1'b0, page_count_q};
		end
	end

	// search start: a zero hint or one at or past the count restarts at page 1
	always_comb begin
		if (hint_q == '0 || {2'b00, hint_q} >= n_eff) begin
			h_start = PAGE_W'(1);
		end else begin
			h_start = {1'b0, hint_q};
		end
	end

	// page named by a free or mark-usable transfer
	assign rel_page = in_data.byte_addr[PAGE_SHIFT +: PAGE_W];
	assign rel_bad  = (|in_data.byte_addr[63:PAGE_SHIFT+PAGE_W]) || (rel_page == '0) ||
		({1'b0, rel_page} >= n_eff);

	// word under inspection; a word never written still holds its reset value
	assign word_eff = rd_vld_q ? ram_rdata : '1;

	// first pass covers [hint, count), the wrapped pass covers [1, hint)
	assign lo_bound = phase_b_q ? PAGE_W'(1) : h_q;
	assign hi_bound = phase_b_q ? {1'b0, h_q} : n_eff;

	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			mask[i] = ({ptr_q, WORD_BITS'(i)} >= lo_bound) &&
				({1'b0, ptr_q, WORD_BITS'(i)} < hi_bound);
		end
		cand = mask & ~word_eff;
		hit  = |cand;
	end

	// lowest free page in the word
	always_comb begin
		hit_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				hit_idx = WORD_BITS'(i);
			end
		end
	end

	assign found_page = {ptr_q, hit_idx};
	assign found_inc  = {1'b0, found_page} + (PAGE_W+1)'(1);
	assign last_page  = n_eff - (PAGE_W+1)'(1);
	assign out_free   = !out_valid_q || out_ready;

	// sequencer: read a word, then modify and write it back on completion
	always_comb begin
		state_d      = state_q;
		hint_d       = hint_q;
		free_d       = free_q;
		ptr_d        = ptr_q;
		phase_b_d    = phase_b_q;
		h_d          = h_q;
		page_d       = page_q;
		lower_d      = lower_q;
		fin_status_d = fin_status_q;
		ram_re       = 1'b0;
		ram_raddr    = ptr_q;
		ram_we       = 1'b0;
		ram_wdata    = word_eff;
		res_load     = 1'b0;
		res_addr     = '0;
		res_status   = ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_data.cmd)
						CMD_ALLOC: begin
							if (n_eff < (PAGE_W+1)'(2)) begin
								fin_status_d = ST_NO_FREE;
								state_d      = S_FIN;
							end else begin
								h_d       = h_start;
								ptr_d     = h_start[PAGE_W-1:WORD_BITS];
								phase_b_d = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = h_start[PAGE_W-1:WORD_BITS];
								state_d   = S_SCAN;
							end
						end
						CMD_FREE, CMD_MARK: begin
							if (rel_bad) begin
								fin_status_d = ST_BAD_PAGE;
								state_d      = S_FIN;
							end else begin
								page_d    = rel_page;
								ptr_d     = rel_page[PAGE_W-1:WORD_BITS];
								lower_d   = (in_data.cmd == CMD_FREE);
								ram_re    = 1'b1;
								ram_raddr = rel_page[PAGE_W-1:WORD_BITS];
								state_d   = S_REL;
							end
						end
						default: begin
							fin_status_d = ST_BAD_PAGE;
							state_d      = S_FIN;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (out_free) begin
						ram_we    = 1'b1;
						ram_wdata = word_eff | (WORD_W'(1) << hit_idx);
						free_d    = (free_q == '0) ? '0 : free_q - PAGE_W'(1);
						// top page wraps the hint to the "past the end" code
						if (32'(found_inc) >= MAX_PAGES) begin
							hint_d = '0;
						end else begin
							hint_d = found_inc[HINT_W-1:0];
						end
						res_load   = 1'b1;
						res_addr   = {found_page[HINT_W-1:0], 12'h000};
						res_status = ST_DONE;
						state_d    = S_IDLE;
					end
				end else if (!phase_b_q) begin
					if (ptr_q == last_page[PAGE_W-1:WORD_BITS]) begin
						if (h_q == PAGE_W'(1)) begin
							// nothing below the hint to wrap to
							if (out_free) begin
								res_load   = 1'b1;
								res_status = ST_NO_FREE;
								state_d    = S_IDLE;
							end
						end else begin
							phase_b_d = 1'b1;
							ptr_d     = '0;
							ram_re    = 1'b1;
							ram_raddr = '0;
						end
					end else begin
						ptr_d     = ptr_q + PTR_W'(1);
						ram_re    = 1'b1;
						ram_raddr = ptr_q + PTR_W'(1);
					end
				end else begin
					if (ptr_q == h_q[PAGE_W-1:WORD_BITS]) begin
						if (out_free) begin
							res_load   = 1'b1;
							res_status = ST_NO_FREE;
							state_d    = S_IDLE;
						end
					end else begin
						ptr_d     = ptr_q + PTR_W'(1);
						ram_re    = 1'b1;
						ram_raddr = ptr_q + PTR_W'(1);
					end
				end
			end
			S_REL: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
					if (!word_eff[page_q[WORD_BITS-1:0]]) begin
						res_status = ST_ALREADY_FREE;
					end else begin
						ram_we     = 1'b1;
						ram_wdata  = word_eff & ~(WORD_W'(1) << page_q[WORD_BITS-1:0]);
						free_d     = free_q + PAGE_W'(1);
						res_status = ST_DONE;
						// a zero hint stands for the end of the bitmap
						if (lower_q && (hint_q == '0 || page_q < {1'b0, hint_q})) begin
							hint_d = page_q[HINT_W-1:0];
						end
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_status = fin_status_q;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// used pages after the command, floored at zero when the count was lowered
	always_comb begin
		if (n_eff > {1'b0, free_d}) begin
			res_used = PAGE_W'(n_eff - {1'b0, free_d});
		end else begin
			res_used = '0;
		end
	end

	bpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NW)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			page_count_q <= PAGE_W'(4096);
			hint_q       <= HINT_W'(1);
			free_q       <= '0;
			word_vld_q   <= '0;
			rd_vld_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			hint_q  <= hint_d;
			free_q  <= free_d;
			if (cfg_we) begin
				page_count_q <= cfg_wdata;
			end
			if (ram_we) begin
				word_vld_q[ptr_q[AW-1:0]] <= 1'b1;
			end
			if (ram_re) begin
				rd_vld_q <= word_vld_q[ram_raddr[AW-1:0]];
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the command in flight and the result register
	always_ff @(posedge clk) begin
		ptr_q        <= ptr_d;
		phase_b_q    <= phase_b_d;
		h_q          <= h_d;
		page_q       <= page_d;
		lower_q      <= lower_d;
		fin_status_q <= fin_status_d;
		if (res_load) begin
			out_q.alloc_addr <= res_addr;
			out_q.status     <= res_status;
			out_q.used_pages <= res_used;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a page handed out is never page zero
	`BPA_ASSERT_IMP(a_alloc_nonzero, (res_load && state_q == S_SCAN && hit), (found_page != '0))
	// write-back only on completion, never alongside a read
	`BPA_ASSERT_IMP(a_write_on_done, ram_we, (res_load && !ram_re))
	// every completion frees the sequencer for the next transfer
	`BPA_ASSERT_NXT(a_done_to_idle, res_load, (state_q == S_IDLE))
	// the wrapped pass is only entered when pages lie below the hint
	`BPA_ASSERT_IMP(a_wrap_needs_room, (state_q == S_SCAN && phase_b_q), (h_q != PAGE_W'(1)))

endmodule
